// File: src/bcr_pkg.sv
// Shared constants, types and a helper function of the blob centroid and radius block.
`timescale 1ns / 1ps
`default_nettype none

package bcr_pkg;

    // Field widths fixed by the block's interface.
    localparam int PIX_W      = 8;
    localparam int CENTER_W   = 10;
    localparam int RADIUS_W   = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Default largest frame dimension.
    localparam int MAX_DIM_DEF = 1024;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd2;

    // Configuration values after reset.
    localparam logic [PIX_W-1:0]      THRESHOLD_RST = 8'd127;
    localparam logic [CFG_DATA_W-1:0] COLUMNS_RST   = 11'd640;
    localparam logic [CFG_DATA_W-1:0] ROWS_RST      = 11'd480;

    // Thresholded pixel values.
    localparam logic [PIX_W-1:0] PIX_FG = 8'd255;
    localparam logic [PIX_W-1:0] PIX_BG = 8'd0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // a pixel beat is taken this cycle
        logic div_start;  // last pixel of a non-empty frame: load the divider
        logic div_step;   // one restoring division step
        logic res_load;   // load the result register from the current pixel
        logic res_final;  // load the result register with the frame features
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;       // the current position is the last pixel of the frame
        logic nonempty;   // the frame holds a foreground pixel, counting this one
        logic out_free;   // the result register can take a value this cycle
    } dp_status_t;

    // A frame dimension of zero counts as one, any value above the limit as the limit.
    function automatic int unsigned eff_dim(input logic [CFG_DATA_W-1:0] v,
                                            input int unsigned max_dim);
        int unsigned r;
        r = 32'(v);
        if (r == 0)
        begin
            r = 1;
        end
        else if (r > max_dim)
        begin
            r = max_dim;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/bcr_if.sv
// Stream and configuration interfaces of the blob centroid and radius block.
`timescale 1ns / 1ps
`default_nettype none

interface bcr_pixel_if
    import bcr_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface bcr_result_if
    import bcr_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [PIX_W-1:0]    binary_pixel;
    logic                frame_done;
    logic [CENTER_W-1:0] center_row;
    logic [CENTER_W-1:0] center_col;
    logic [RADIUS_W-1:0] radius;
    logic                empty_frame;

    modport source (output valid, output binary_pixel, output frame_done,
                    output center_row, output center_col, output radius,
                    output empty_frame, input ready);
    modport sink   (input valid, input binary_pixel, input frame_done,
                    input center_row, input center_col, input radius,
                    input empty_frame, output ready);
endinterface

interface bcr_cfg_if
    import bcr_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/bcr_ctrl.sv
// Controller of the blob centroid and radius block: pixel flow and divide sequencing.
`timescale 1ns / 1ps
`default_nettype none

module bcr_ctrl
    import bcr_pkg::*;
#(
    parameter int SUM_W = 30
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       pix_valid,
    output logic            pix_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    typedef enum logic [1:0] {
        S_RUN,
        S_DIV,
        S_FIN
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                accept;

    assign pix_ready = (state_reg == S_RUN) && status.out_free;
    assign accept    = pix_ready && pix_valid;

    always_comb
    begin
        cmd.accept    = accept;
        cmd.div_start = accept && status.last && status.nonempty;
        cmd.res_load  = accept && !(status.last && status.nonempty);
        cmd.div_step  = (state_reg == S_DIV);
        cmd.res_final = (state_reg == S_FIN) && status.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_RUN:
            begin
                if (cmd.div_start)
                begin
                    state_next = S_DIV;
                    step_next  = STEP_W'(SUM_W - 1);
                end
            end
            S_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

// File: src/bcr_dpath.sv
// Datapath of the blob centroid and radius block: config, accumulators, divider, result.
`timescale 1ns / 1ps
`default_nettype none

module bcr_dpath
    import bcr_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    parameter int POS_W   = $clog2(MAX_DIM),
    parameter int CNT_W   = 2 * POS_W + 1,
    parameter int SUM_W   = 3 * POS_W
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    input  wire logic [PIX_W-1:0]      pixel,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [PIX_W-1:0]           out_binary_pixel,
    output logic                       out_frame_done,
    output logic [CENTER_W-1:0]        out_center_row,
    output logic [CENTER_W-1:0]        out_center_col,
    output logic [RADIUS_W-1:0]        out_radius,
    output logic                       out_empty_frame
);

    localparam int DIM_W  = POS_W + 1;
    localparam int SPAN_W = POS_W + 1;

    // Configuration.
    logic [PIX_W-1:0]      threshold_reg;
    logic [CFG_DATA_W-1:0] columns_reg;
    logic [CFG_DATA_W-1:0] rows_reg;

    // Frame position and features.
    logic [POS_W-1:0]      row_pos_reg;
    logic [POS_W-1:0]      col_pos_reg;
    logic [POS_W-1:0]      top_reg;
    logic [POS_W-1:0]      bottom_reg;
    logic [POS_W-1:0]      left_reg;
    logic [POS_W-1:0]      right_reg;
    logic [SUM_W-1:0]      row_sum_reg;
    logic [SUM_W-1:0]      col_sum_reg;
    logic [CNT_W-1:0]      count_reg;

    // Divider: the numerators shift out as the quotients shift in.
    logic [SUM_W-1:0]      quo_row_reg;
    logic [SUM_W-1:0]      quo_col_reg;
    logic [CNT_W-1:0]      rem_row_reg;
    logic [CNT_W-1:0]      rem_col_reg;
    logic [CNT_W-1:0]      den_reg;
    logic [RADIUS_W-1:0]   radius_reg;
    logic                  last_fg_reg;

    // Result register.
    logic                  out_valid_reg;
    logic [PIX_W-1:0]      out_bin_reg;
    logic                  out_done_reg;
    logic [CENTER_W-1:0]   out_crow_reg;
    logic [CENTER_W-1:0]   out_ccol_reg;
    logic [RADIUS_W-1:0]   out_rad_reg;
    logic                  out_empty_reg;

    logic [DIM_W-1:0]      cols_eff;
    logic [DIM_W-1:0]      rows_eff;
    logic                  fg;
    logic                  row_end;
    logic                  col_end;
    logic                  last;
    logic [POS_W-1:0]      top_next;
    logic [POS_W-1:0]      bottom_next;
    logic [POS_W-1:0]      left_next;
    logic [POS_W-1:0]      right_next;
    logic [SUM_W-1:0]      row_sum_next;
    logic [SUM_W-1:0]      col_sum_next;
    logic [CNT_W-1:0]      count_next;
    logic [SPAN_W-1:0]     span_sum;
    logic                  restart;
    logic [CNT_W:0]        trial_row;
    logic [CNT_W:0]        trial_col;
    logic                  ge_row;
    logic                  ge_col;

    assign cols_eff = DIM_W'(eff_dim(columns_reg, MAX_DIM));
    assign rows_eff = DIM_W'(eff_dim(rows_reg, MAX_DIM));

    assign fg      = pixel > threshold_reg;
    assign row_end = ({1'b0, row_pos_reg} + DIM_W'(1)) >= rows_eff;
    assign col_end = ({1'b0, col_pos_reg} + DIM_W'(1)) >= cols_eff;
    assign last    = row_end && col_end;

    // Feature values including the current pixel.
    always_comb
    begin
        top_next     = top_reg;
        bottom_next  = bottom_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        row_sum_next = row_sum_reg;
        col_sum_next = col_sum_reg;
        count_next   = count_reg;
        if (fg)
        begin
            if (row_pos_reg < top_reg)
            begin
                top_next = row_pos_reg;
            end
            if (row_pos_reg > bottom_reg)
            begin
                bottom_next = row_pos_reg;
            end
            if (col_pos_reg < left_reg)
            begin
                left_next = col_pos_reg;
            end
            if (col_pos_reg > right_reg)
            begin
                right_next = col_pos_reg;
            end
            row_sum_next = row_sum_reg + SUM_W'(row_pos_reg);
            col_sum_next = col_sum_reg + SUM_W'(col_pos_reg);
            count_next   = count_reg + CNT_W'(1);
        end
    end

    assign span_sum = SPAN_W'(bottom_next - top_next) + SPAN_W'(right_next - left_next);

    assign status.last     = last;
    assign status.nonempty = (count_next != '0);
    assign status.out_free = !out_valid_reg || out_ready;

    // A frame size write restarts the frame.
    always_comb
    begin
        restart = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index) inside
                CFG_COLUMNS, CFG_ROWS: restart = 1'b1;
                default:               restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            columns_reg   <= COLUMNS_RST;
            rows_reg      <= ROWS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_data[PIX_W-1:0];
                CFG_COLUMNS:   columns_reg   <= cfg_data;
                CFG_ROWS:      rows_reg      <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Top and left start at all ones: they are read only once a foreground
    // pixel has pulled them down to a real position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            top_reg     <= '1;
            bottom_reg  <= '0;
            left_reg    <= '1;
            right_reg   <= '0;
            row_sum_reg <= '0;
            col_sum_reg <= '0;
            count_reg   <= '0;
        end
        else if (restart || (cmd.accept && last))
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            top_reg     <= '1;
            bottom_reg  <= '0;
            left_reg    <= '1;
            right_reg   <= '0;
            row_sum_reg <= '0;
            col_sum_reg <= '0;
            count_reg   <= '0;
        end
        else if (cmd.accept)
        begin
            top_reg     <= top_next;
            bottom_reg  <= bottom_next;
            left_reg    <= left_next;
            right_reg   <= right_next;
            row_sum_reg <= row_sum_next;
            col_sum_reg <= col_sum_next;
            count_reg   <= count_next;
            if (col_end)
            begin
                col_pos_reg <= '0;
                row_pos_reg <= row_pos_reg + POS_W'(1);
            end
            else
            begin
                col_pos_reg <= col_pos_reg + POS_W'(1);
            end
        end
    end

    // Restoring division, one quotient bit per cycle for both centroids.
    assign trial_row = {rem_row_reg, quo_row_reg[SUM_W-1]};
    assign trial_col = {rem_col_reg, quo_col_reg[SUM_W-1]};
    assign ge_row    = trial_row >= {1'b0, den_reg};
    assign ge_col    = trial_col >= {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_row_reg <= row_sum_next;
            quo_col_reg <= col_sum_next;
            rem_row_reg <= '0;
            rem_col_reg <= '0;
            den_reg     <= count_next;
            radius_reg  <= RADIUS_W'(span_sum >> 2);
            last_fg_reg <= fg;
        end
        else if (cmd.div_step)
        begin
            quo_row_reg <= {quo_row_reg[SUM_W-2:0], ge_row};
            quo_col_reg <= {quo_col_reg[SUM_W-2:0], ge_col};
            rem_row_reg <= ge_row ? CNT_W'(trial_row - {1'b0, den_reg})
                                  : trial_row[CNT_W-1:0];
            rem_col_reg <= ge_col ? CNT_W'(trial_col - {1'b0, den_reg})
                                  : trial_col[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load || cmd.res_final)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_bin_reg   <= fg ? PIX_FG : PIX_BG;
            out_done_reg  <= last;
            out_crow_reg  <= '0;
            out_ccol_reg  <= '0;
            out_rad_reg   <= '0;
            out_empty_reg <= last && (count_next == '0);
        end
        else if (cmd.res_final)
        begin
            out_bin_reg   <= last_fg_reg ? PIX_FG : PIX_BG;
            out_done_reg  <= 1'b1;
            out_crow_reg  <= CENTER_W'(quo_row_reg);
            out_ccol_reg  <= CENTER_W'(quo_col_reg);
            out_rad_reg   <= radius_reg;
            out_empty_reg <= 1'b0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_binary_pixel = out_bin_reg;
    assign out_frame_done   = out_done_reg;
    assign out_center_row   = out_crow_reg;
    assign out_center_col   = out_ccol_reg;
    assign out_radius       = out_rad_reg;
    assign out_empty_frame  = out_empty_reg;

endmodule

`default_nettype wire

// File: src/blob_centroid_radius.sv
// Top level of the blob centroid and radius block.
`timescale 1ns / 1ps
`default_nettype none

// Thresholds a raster-order gray frame and measures its foreground blob. Every
// pixel beat on pix_in gives one result beat on res_out carrying the binary
// pixel (255 or 0); the beat for the last pixel of the frame also carries
// frame_done, the truncated centroid row and column, the radius
// floor((height span + width span) / 4) and, for a frame with no foreground
// pixel, empty_frame with zero features. Ordinary pixels flow at one beat per
// clock while the result side takes its beats, since a result register
// separates the two sides. For the last pixel of a non-empty frame, the cycle
// that accepts it also loads a restoring divider, which then works through the
// quotient bits of the row and column sums side by side, and the result is
// loaded after the last quotient bit, later if the result beat ahead of it
// is still stalled. The input is held off from that acceptance until the
// result is loaded. Configuration beats on cfg_in are always
// taken: index 0 is the threshold (a pixel strictly above it is foreground),
// index 1 the columns per row and index 2 the rows per frame; a size of zero
// acts as one and a size above MAX_DIM as MAX_DIM. Writing either size starts
// a fresh frame, and other indexes are ignored. Write the configuration only
// while no pixel is in flight.
module blob_centroid_radius
    import bcr_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    bcr_pixel_if.sink    pix_in,
    bcr_result_if.source res_out,
    bcr_cfg_if.sink      cfg_in
);

    // Position, count and sum widths follow from the largest frame edge.
    localparam int POS_W = $clog2(MAX_DIM);
    localparam int CNT_W = 2 * POS_W + 1;
    localparam int SUM_W = 3 * POS_W;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       cfg_we;

    // Configuration is taken in any cycle.
    assign cfg_in.ready = 1'b1;
    assign cfg_we       = cfg_in.valid;

    // The controller owns the pixel handshake and sequences the divider.
    bcr_ctrl #(
        .SUM_W (SUM_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_in.valid),
        .pix_ready (pix_in.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the configuration, the frame accumulators, the
    // divider and the result register.
    bcr_dpath #(
        .MAX_DIM (MAX_DIM),
        .POS_W   (POS_W),
        .CNT_W   (CNT_W),
        .SUM_W   (SUM_W)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .pixel            (pix_in.pixel),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_in.index),
        .cfg_data         (cfg_in.data),
        .out_valid        (res_out.valid),
        .out_ready        (res_out.ready),
        .out_binary_pixel (res_out.binary_pixel),
        .out_frame_done   (res_out.frame_done),
        .out_center_row   (res_out.center_row),
        .out_center_col   (res_out.center_col),
        .out_radius       (res_out.radius),
        .out_empty_frame  (res_out.empty_frame)
    );

endmodule

`default_nettype wire

// File: src/bcr_checker.sv
// Port-level assertions of the blob centroid and radius block and their binding.
`timescale 1ns / 1ps
`default_nettype none

module bcr_checker
    import bcr_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic [PIX_W-1:0]    binary_pixel,
    input wire logic                frame_done,
    input wire logic [CENTER_W-1:0] center_row,
    input wire logic [CENTER_W-1:0] center_col,
    input wire logic [RADIUS_W-1:0] radius,
    input wire logic                empty_frame
);

    // A result beat stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat withdrawn before it was taken");

    // A stalled result beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(binary_pixel) && $stable(frame_done) && $stable(center_row) &&
            $stable(center_col) && $stable(radius) && $stable(empty_frame))
        else $error("stalled result beat changed");

    // The binary pixel is either background or foreground.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (binary_pixel == PIX_FG) || (binary_pixel == PIX_BG))
        else $error("binary pixel is neither 0 nor 255");

    // Features are zero except on the last pixel of a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_done |->
            center_row == '0 && center_col == '0 && radius == '0 && !empty_frame)
        else $error("features reported outside the last pixel");

    // An empty frame is flagged only at the frame end and with zero features.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_frame |->
            frame_done && center_row == '0 && center_col == '0 && radius == '0)
        else $error("empty frame reported with features");

endmodule

bind blob_centroid_radius bcr_checker u_bcr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (res_out.valid),
    .out_ready    (res_out.ready),
    .binary_pixel (res_out.binary_pixel),
    .frame_done   (res_out.frame_done),
    .center_row   (res_out.center_row),
    .center_col   (res_out.center_col),
    .radius       (res_out.radius),
    .empty_frame  (res_out.empty_frame)
);

`default_nettype wire
